### src/assert_macros.svh
// concurrent assertion helpers, reset held low disables the check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define A8E_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define A8E_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/a8e_pkg.sv
`default_nettype none

package a8e_pkg;

    localparam int MAG_W      = 16;
    localparam int COEF_W     = 26;
    localparam int PROD_W     = MAG_W + COEF_W;
    localparam int FADE_STEPS = 2048;
    localparam int FADE_W     = 12;

    typedef struct packed {
        logic        first_of_file;
        logic [15:0] chan0_raw;
        logic [15:0] chan1_raw;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        page_end;
        logic [15:0] page_number;
    } t_out_item;

    typedef enum logic [1:0] {
        MUL_FADE,
        MUL_EMPH,
        MUL_TRACK
    } t_mul_op;

    typedef struct packed {
        t_mul_op             op;
        logic [MAG_W-1:0]    mag;
        logic [FADE_W-1:0]   fade_level;
    } t_mul_req;

endpackage

`default_nettype wire

### src/audio_to_8bit_emphasis_converter.sv
// pcm frame to 8-bit emphasized byte converter
//
// input channel: one pcm frame per request on i_in (valid/ready). channels are
// averaged, faded once the configured page count is reached, halved, emphasized
// against a tracked value, clamped and cut to one offset-binary byte.
// output channel: one byte per request on o_out (valid/ready), with a page-end
// flag every PAGE_BYTES bytes and the 1-based page number.
// config port: i_cfg_we / i_cfg_idx / i_cfg_data, taken in the same cycle;
// write it only while the block is idle.
// timing: a request is processed by one shared 16x26 multiplier under an
// eight-state sequencer (fade, emphasis and tracking products, each followed
// by a register). the result is written to the output register as the
// sequencer returns to idle, o_in_ready rises with it and the next request
// can then be taken; a new request is not accepted while one is in progress.
// stall: the result waits in the output register; a later request is accepted
// and processed, then holds in its last state until the output register frees.
// reset: synchronous, active low; clears the sequencer, tracked value, fade,
// page counters and output valid, and restores mono 16-bit with no fade.
`default_nettype none

module audio_to_8bit_emphasis_converter
    import a8e_pkg::*;
#(
    parameter int PAGE_BYTES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out
);

`include "assert_macros.svh"

    localparam int BP_W        = $clog2(PAGE_BYTES);
    localparam int FADE_SHIFT  = 11;
    localparam int EMPH_SHIFT  = 20;
    localparam int TRACK_SHIFT = 30;
    localparam int EMPH_MAG_W  = 21;
    localparam int TRACK_MAG_W = 12;

    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_WIDE_SAMPLES  = 2'd1;
    localparam logic [1:0] CFG_FADE_START    = 2'd2;

    localparam logic signed [22:0] X_MAX = 23'sd32767;
    localparam logic signed [22:0] X_MIN = -23'sd32767;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FADE,
        S_DIFF,
        S_EMPH,
        S_CLAMP,
        S_TDIFF,
        S_TRACK,
        S_UPD
    } t_state;

    t_state              r_state;
    logic [1:0]          r_chan;
    logic                r_wide;
    logic [15:0]         r_fade_start;
    logic [15:0]         r_t;
    logic [FADE_W-1:0]   r_fade;
    logic [BP_W-1:0]     r_bp;
    logic [15:0]         r_pages;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [15:0]         r_s;
    logic [MAG_W-1:0]    r_mag;
    logic                r_neg;
    logic [15:0]         r_x;

    t_mul_req            mul_req;
    logic [PROD_W-1:0]   prod;

    logic [15:0]            samp0, samp1;
    logic [16:0]            sum, sum_adj, avg_w, avg_neg;
    logic [MAG_W-1:0]       avg_mag;
    logic [MAG_W-1:0]       fade_mag;
    logic [16:0]            fade_pos, s_fade;
    logic [15:0]            s_half;
    logic [16:0]            d, d_neg;
    logic [MAG_W-1:0]       d_mag;
    logic [EMPH_MAG_W-1:0]  e_mag;
    logic [22:0]            e_pos, e_q, x_w;
    logic [15:0]            x_c, x_floor;
    logic [16:0]            d2, d2_neg;
    logic [MAG_W-1:0]       d2_mag;
    logic [TRACK_MAG_W-1:0] tq;
    logic [16:0]            t_pos, t_del;
    logic [15:0]            t_next;
    logic [15:0]            page_next;
    logic                   page_last;
    logic                   out_free;

    // sample decode and channel average, truncating toward zero
    always_comb begin
        samp0 = r_wide ? i_in.chan0_raw
                       : {~i_in.chan0_raw[7], i_in.chan0_raw[6:0], 8'h00};
        samp1 = r_wide ? i_in.chan1_raw
                       : {~i_in.chan1_raw[7], i_in.chan1_raw[6:0], 8'h00};
        sum     = {samp0[15], samp0} + {samp1[15], samp1};
        sum_adj = sum + {16'b0, sum[16]};
        avg_w   = r_chan[1] ? {sum_adj[16], sum_adj[16:1]} : {samp0[15], samp0};
        avg_neg = ~avg_w + 17'd1;
        avg_mag = avg_w[16] ? avg_neg[15:0] : avg_w[15:0];
    end

    // fade result, halving and emphasis difference
    always_comb begin
        fade_mag = prod[FADE_SHIFT +: MAG_W];
        fade_pos = {1'b0, fade_mag};
        if (r_fade != '0) begin
            s_fade = r_neg ? (~fade_pos + 17'd1) : fade_pos;
        end else begin
            s_fade = {r_s[15], r_s};
        end
        s_half = s_fade[16:1];
        d      = {s_half[15], s_half} - {r_t[15], r_t};
        d_neg  = ~d + 17'd1;
        d_mag  = d[16] ? d_neg[15:0] : d[15:0];
    end

    // emphasis result, clamp and floor to a multiple of 256
    always_comb begin
        e_mag = prod[EMPH_SHIFT +: EMPH_MAG_W];
        e_pos = {2'b0, e_mag};
        e_q   = r_neg ? (~e_pos + 23'd1) : e_pos;
        x_w   = e_q + {{7{r_t[15]}}, r_t};
        if ($signed(x_w) > X_MAX) begin
            x_c = X_MAX[15:0];
        end else if ($signed(x_w) < X_MIN) begin
            x_c = X_MIN[15:0];
        end else begin
            x_c = x_w[15:0];
        end
        x_floor = {x_c[15:8], 8'h00};
    end

    // tracked value update
    always_comb begin
        d2      = {r_x[15], r_x} - {r_t[15], r_t};
        d2_neg  = ~d2 + 17'd1;
        d2_mag  = d2[16] ? d2_neg[15:0] : d2[15:0];
        tq      = prod[TRACK_SHIFT +: TRACK_MAG_W];
        t_pos   = {5'b0, tq};
        t_del   = r_neg ? (~t_pos + 17'd1) : t_pos;
        t_next  = r_t + t_del[15:0];
    end

    assign page_next = r_pages + 16'd1;
    assign page_last = (r_bp == BP_W'(PAGE_BYTES - 1));
    assign out_free  = !r_out_valid || i_out_ready;

    // tracking product stays selected while the result waits
    always_comb begin
        mul_req.mag        = r_mag;
        mul_req.fade_level = r_fade;
        unique case (r_state)
            S_EMPH:         mul_req.op = MUL_EMPH;
            S_TRACK, S_UPD: mul_req.op = MUL_TRACK;
            default:        mul_req.op = MUL_FADE;
        endcase
    end

    a8e_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chan       <= 2'd1;
            r_wide       <= 1'b1;
            r_fade_start <= '0;
            r_t          <= '0;
            r_fade       <= '0;
            r_bp         <= '0;
            r_pages      <= '0;
            r_out_valid  <= 1'b0;
            r_out        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CHANNEL_COUNT: r_chan       <= i_cfg_data[1:0];
                    CFG_WIDE_SAMPLES:  r_wide       <= i_cfg_data[0];
                    CFG_FADE_START:    r_fade_start <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready && r_state != S_UPD) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in.first_of_file) begin
                            r_t     <= '0;
                            r_fade  <= '0;
                            r_bp    <= '0;
                            r_pages <= '0;
                        end
                        r_state <= S_FADE;
                    end
                end
                S_FADE:  r_state <= S_DIFF;
                S_DIFF: begin
                    if (r_fade > FADE_W'(1)) begin
                        r_fade <= r_fade - FADE_W'(1);
                    end
                    r_state <= S_EMPH;
                end
                S_EMPH:  r_state <= S_CLAMP;
                S_CLAMP: r_state <= S_TDIFF;
                S_TDIFF: r_state <= S_TRACK;
                S_TRACK: r_state <= S_UPD;
                S_UPD: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.out_byte    <= {~r_x[15], r_x[14:8]};
                        r_out.page_end    <= page_last;
                        r_out.page_number <= page_next;
                        r_t               <= t_next;
                        if (page_last) begin
                            r_bp    <= '0;
                            r_pages <= page_next;
                            if (r_fade_start != '0 && page_next == r_fade_start) begin
                                r_fade <= FADE_W'(FADE_STEPS);
                            end
                        end else begin
                            r_bp <= r_bp + BP_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_s   <= avg_w[15:0];
                r_mag <= avg_mag;
                r_neg <= avg_w[16];
            end
            S_DIFF: begin
                r_mag <= d_mag;
                r_neg <= d[16];
            end
            S_CLAMP: r_x <= x_floor;
            S_TDIFF: begin
                r_mag <= d2_mag;
                r_neg <= d2[16];
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `A8E_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready, "request accepted while busy")
    `A8E_ASSERT_IMP(a_page_wrap, i_clk, i_rst_n,
        o_out_valid && o_out.page_end, r_bp == '0, "byte position not wrapped at page end")
    `A8E_ASSERT_IMP(a_fade_range, i_clk, i_rst_n,
        r_fade != '0, r_fade <= FADE_W'(FADE_STEPS), "fade level above full scale")
    `A8E_ASSERT_IMP(a_x_floor, i_clk, i_rst_n,
        r_state == S_TDIFF, r_x[7:0] == 8'h00, "emphasized sample low byte not cleared")

endmodule

`default_nettype wire

### src/a8e_mul.sv
`default_nettype none

module a8e_mul
    import a8e_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_mul_req          i_req,
    output logic [PROD_W-1:0]      o_prod
);

    // reciprocal constants: floor(m*441/20) = (m*K_EMPH)>>20,
    // floor(m*20/441) = (m*K_TRACK)>>30, exact for 16-bit magnitudes
    localparam logic [COEF_W-1:0] K_EMPH  = 26'd23121101;
    localparam logic [COEF_W-1:0] K_TRACK = 26'd48695775;

    logic [COEF_W-1:0] coef;
    logic [PROD_W-1:0] r_prod;

    always_comb begin
        unique case (i_req.op)
            MUL_FADE:  coef = COEF_W'(i_req.fade_level);
            MUL_EMPH:  coef = K_EMPH;
            MUL_TRACK: coef = K_TRACK;
            default:   coef = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.mag) * PROD_W'(coef);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

### tb/sv/audio_to_8bit_emphasis_converter_tb.sv
`timescale 1ns / 1ps

module audio_to_8bit_emphasis_converter_tb;
    import a8e_pkg::*;

    localparam int PAGE_BYTES = 256;
    localparam int SETTLE_CYCLES = 12;
    localparam longint PREEMPH_RATE = 44100;
    localparam longint TRACK_RATE = 2000;
    localparam longint FULL_SCALE = 32'h7FFF;
    localparam longint MID_CODE = 32768;

    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_WIDE = 2'd1;
    localparam logic [1:0] REG_FADE_START = 2'd2;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    t_in_item    in_item = '0;
    logic        out_ready = 1'b0;
    wire         o_in_ready;
    wire         o_out_valid;
    t_out_item   out_item;

    // shadow of the configuration registers
    logic [1:0]  cfg_chans = 2'd1;
    logic        cfg_wide = 1'b1;
    logic [15:0] cfg_fade_start = '0;

    // shadow of the converter state
    longint      emph_track = 0;
    int          fade_gain = 0;
    int          page_fill = 0;
    logic [15:0] pages_done = '0;

    t_in_item    pending_frames[$];
    t_out_item   expected_bytes[$];
    t_out_item   want_byte;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          walk_level = 0;
    int          error_count = 0;

    audio_to_8bit_emphasis_converter #(
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_in(in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out(out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("audio_to_8bit_emphasis_converter verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        begin
            error_count++;
            $display("ERROR %0t: %s", $time, what);
        end
    endtask

    function automatic longint pcm_value(input logic [15:0] raw);
        if (cfg_wide)
            return longint'($signed(raw));
        return (longint'(raw[7:0]) - 128) * 256;
    endfunction

    function automatic t_out_item convert_frame(input t_in_item frame);
        longint    s;
        longint    x;
        longint    t;
        int        chans;
        t_out_item res;
        begin
            if (frame.first_of_file) begin
                emph_track = 0;
                fade_gain = 0;
                page_fill = 0;
                pages_done = '0;
            end
            chans = (cfg_chans == 2'd0) ? 1 : (cfg_chans == 2'd3) ? 2 : int'(cfg_chans);
            s = pcm_value(frame.chan0_raw);
            if (chans == 2)
                s += pcm_value(frame.chan1_raw);
            s = s / longint'(chans);
            if (fade_gain != 0) begin
                s = (s * fade_gain) / FADE_STEPS;
                if (fade_gain != 1)
                    fade_gain--;
            end
            s = s >>> 1;
            t = emph_track;
            x = ((s - t) * PREEMPH_RATE) / TRACK_RATE + t;
            if (x > FULL_SCALE)
                x = FULL_SCALE;
            if (x < -FULL_SCALE)
                x = -FULL_SCALE;
            x = ((x + MID_CODE) & ~longint'(255)) - MID_CODE;
            emph_track = t + ((x - t) * TRACK_RATE) / PREEMPH_RATE;
            res.page_number = pages_done + 16'd1;
            res.page_end = 1'b0;
            page_fill++;
            if (page_fill >= PAGE_BYTES) begin
                res.page_end = 1'b1;
                page_fill = 0;
                pages_done = pages_done + 16'd1;
                if (cfg_fade_start != 0 && pages_done == cfg_fade_start)
                    fade_gain = FADE_STEPS;
            end
            res.out_byte = 8'((x + MID_CODE) >>> 8);
            return res;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                expected_bytes.push_back(convert_frame(in_item));
            if (!in_valid || o_in_ready) begin
                if (pending_frames.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_item <= pending_frames.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with no request outstanding",
                                              out_item.out_byte));
                end else begin
                    want_byte = expected_bytes.pop_front();
                    if (out_item.out_byte !== want_byte.out_byte)
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  out_item.out_byte, want_byte.out_byte));
                    if (out_item.page_end !== want_byte.page_end)
                        report_mismatch($sformatf("page_end got %0b want %0b",
                                                  out_item.page_end, want_byte.page_end));
                    if (out_item.page_number !== want_byte.page_number)
                        report_mismatch($sformatf("page_number got %0d want %0d",
                                                  out_item.page_number, want_byte.page_number));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        begin
            @(posedge i_clk);
            cfg_we <= 1'b1;
            cfg_idx <= idx;
            cfg_data <= value;
            case (idx)
                REG_CHANNELS: cfg_chans = value[1:0];
                REG_WIDE: cfg_wide = value[0];
                REG_FADE_START: cfg_fade_start = value;
                default: ;
            endcase
            @(posedge i_clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic wait_for_drain();
        begin
            @(negedge i_clk);
            while (pending_frames.size() != 0 || in_valid || expected_bytes.size() != 0)
                @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic push_frame(input logic fof, input logic [15:0] c0, input logic [15:0] c1);
        t_in_item f;
        begin
            f.first_of_file = fof;
            f.chan0_raw = c0;
            f.chan1_raw = c1;
            pending_frames.push_back(f);
        end
    endtask

    task automatic queue_random(input int count);
        int          kind;
        int          step;
        logic [15:0] v0;
        logic [15:0] v1;
        begin
            repeat (count) begin
                kind = $urandom_range(0, 9);
                if (kind == 9)
                    walk_level = int'($urandom_range(0, 65535)) - 32768;
                if (kind <= 5 || kind == 9) begin
                    // slowly moving signal keeps the emphasis out of the clamp
                    step = int'($urandom_range(0, 600)) - 300;
                    walk_level += step;
                    if (walk_level > 32767)
                        walk_level = 32767;
                    if (walk_level < -32768)
                        walk_level = -32768;
                    v0 = 16'(walk_level);
                    v1 = 16'(walk_level + int'($urandom_range(0, 400)) - 200);
                end else if (kind <= 7) begin
                    v0 = 16'($urandom);
                    v1 = 16'($urandom);
                end else begin
                    v0 = {1'($urandom_range(0, 1)), {15{1'($urandom_range(0, 1))}}};
                    v1 = {1'($urandom_range(0, 1)), {15{1'($urandom_range(0, 1))}}};
                end
                if (!cfg_wide) begin
                    v0 = {8'($urandom), v0[15:8] ^ 8'h80};
                    v1 = {8'($urandom), v1[15:8] ^ 8'h80};
                end
                push_frame($urandom_range(0, 399) == 0, v0, v1);
            end
        end
    endtask

    task automatic run_phase(input logic [1:0] chans, input logic wide,
                             input logic [15:0] fade_at, input int idle_pct,
                             input int stall_pct, input int count);
        begin
            wait_for_drain();
            write_reg(REG_CHANNELS, {14'd0, chans});
            write_reg(REG_WIDE, {15'd0, wide});
            write_reg(REG_FADE_START, fade_at);
            send_idle_pct = idle_pct;
            recv_stall_pct = stall_pct;
            queue_random(count);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stereo 16-bit extremes
        run_phase(2'd2, 1'b1, 16'd0, 0, 0, 0);
        push_frame(1'b1, 16'h0000, 16'h0000);
        push_frame(1'b0, 16'h7FFF, 16'h7FFF);
        push_frame(1'b0, 16'h7FFF, 16'h7FFF);
        push_frame(1'b0, 16'h8000, 16'h8000);
        push_frame(1'b0, 16'h8000, 16'h8000);
        push_frame(1'b0, 16'h7FFF, 16'h8000);
        push_frame(1'b0, 16'hFFFF, 16'h0001);
        push_frame(1'b0, 16'h0001, 16'h0000);
        push_frame(1'b1, 16'h8000, 16'h7FFF);
        push_frame(1'b0, 16'hFFFF, 16'hFFFF);
        push_frame(1'b0, 16'h0000, 16'h8000);
        push_frame(1'b0, 16'h7FFF, 16'h0000);

        // out-of-range channel count, 8-bit samples with junk high bytes
        run_phase(2'd3, 1'b0, 16'hFFFF, 0, 0, 0);
        push_frame(1'b1, 16'hFF00, 16'h00FF);
        push_frame(1'b0, 16'h00FF, 16'hFFFF);
        push_frame(1'b0, 16'hFF80, 16'h0080);
        push_frame(1'b0, 16'h0000, 16'h0000);
        push_frame(1'b0, 16'h1234, 16'hED7F);
        push_frame(1'b1, 16'h00FF, 16'hFF00);
        push_frame(1'b0, 16'h8000, 16'h7FFF);
        push_frame(1'b0, 16'h00FF, 16'h00FF);

        run_phase(2'd0, 1'b1, 16'd0, 0, 0, 120);

        // fade after the first page, sender holds off once mid-phase
        run_phase(2'd2, 1'b1, 16'd1, 79, 0, 150);
        wait_for_drain();
        queue_random(150);

        run_phase(2'd1, 1'b0, 16'd2, 0, 79, 200);
        run_phase(2'd3, 1'b1, 16'd2, 27, 27, 150);
        wait_for_drain();

        if (error_count == 0)
            $display("audio_to_8bit_emphasis_converter verification clean");
        else
            $display("audio_to_8bit_emphasis_converter verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/a8e_pkg.sv
src/a8e_mul.sv
src/audio_to_8bit_emphasis_converter.sv
tb/sv/audio_to_8bit_emphasis_converter_tb.sv
